// ===== design/escaped_hex_text_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Escaped hex text decoder assertion macros
// Shared property templates for the decoder's port checker.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_HEX_TEXT_DECODER_ASSERT_SVH
`define ESCAPED_HEX_TEXT_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EHD_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ehd: same-cycle property failed");

// Next-cycle implication, disabled while reset is asserted.
`define EHD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ehd: next-cycle property failed");

`endif

// ===== design/ehd_pkg.sv =====
// ----------------------------------------------------------------------------
// ehd_pkg
// Types, character codes and the hex digit decode for the escaped hex decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ehd_pkg;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
    localparam logic [7:0] CHAR_LOWER_F   = 8'h66;
    localparam logic [3:0] NIBBLE_TEN     = 4'd10;

    typedef struct packed {
        logic [7:0] char_in;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] byte_out;
        logic       format_error;
        logic       string_done;
    } out_item_t;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_ESC  = 3'b010,
        PH_LOW  = 3'b100
    } phase_t;

    // Bit 4 set: not a lowercase hex digit. Bits 3:0: the digit value.
    function automatic logic [4:0] nibble_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'b10000;
        if (c >= CHAR_ZERO && c <= CHAR_NINE)
        begin
            r = {1'b0, 4'(c - CHAR_ZERO)};
        end
        else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_F)
        begin
            r = {1'b0, 4'(c - CHAR_LOWER_A) + NIBBLE_TEN};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== design/escaped_hex_text_decoder.sv =====
// ----------------------------------------------------------------------------
// escaped_hex_text_decoder
// Streaming decoder for hex text, plain digit pairs or backslash escapes.
// ----------------------------------------------------------------------------
//  channel | direction | payload      | transfer when
//  in      | in        | in_item_t    | in_valid  & in_ready
//  out     | out       | out_item_t   | out_valid & out_ready
//  cfg     | in        | escaped_mode | cfg_valid & cfg_ready (always ready)
//
//  One character per clock while the output is not stalled. A character
//  waits in the input register, is decoded by the logic that follows it,
//  and its result (if any) lands in the output register. The output
//  register is the only stall point; when it holds and is not taken, the
//  input register holds too and in_ready drops. Reset (rst_n low,
//  asynchronous) empties both registers, returns the decode state to idle
//  and sets escaped mode.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_hex_text_decoder (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               in_valid,
    output logic              in_ready,
    input  ehd_pkg::in_item_t in_data,
    output logic              out_valid,
    input  wire               out_ready,
    output ehd_pkg::out_item_t out_data,
    input  wire               cfg_valid,
    output logic              cfg_ready,
    input  wire               cfg_data
);
    import ehd_pkg::*;

    // Input register
    logic      in_valid_reg;
    in_item_t  in_item_reg;

    // Decode state
    phase_t     phase_reg,   phase_next;
    logic [3:0] nibble_reg,  nibble_next;
    logic       discard_reg, discard_next;
    logic       escaped_mode_reg;

    // Result register
    logic      out_valid_reg;
    out_item_t out_item_reg;

    // Decode results for the character in the input register
    logic      emit;
    out_item_t result;
    logic [4:0] digit;
    logic      bad_digit;
    logic      is_bs;
    logic      last;

    logic      advance;
    logic      fire;

    // The output register can take a new value when it is empty or drained now.
    assign advance   = !out_valid_reg || out_ready;
    assign fire      = in_valid_reg && advance;
    assign in_ready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

    assign digit     = nibble_decode(in_item_reg.char_in);
    assign bad_digit = digit[4];
    assign is_bs     = (in_item_reg.char_in == CHAR_BACKSLASH);
    assign last      = in_item_reg.is_last;

    always_comb
    begin
        phase_next   = phase_reg;
        nibble_next  = nibble_reg;
        discard_next = discard_reg;
        emit         = 1'b0;
        result       = '{byte_out: in_item_reg.char_in, format_error: 1'b0,
                         string_done: last};

        // A failing character reports one error result and ends the string;
        // drop everything after it up to the last flag.
        priority if (discard_reg)
        begin
            if (last)
            begin
                discard_next = 1'b0;
                phase_next   = PH_IDLE;
                nibble_next  = '0;
            end
        end
        else if (phase_reg == PH_LOW)
        begin
            if (bad_digit)
            begin
                emit = 1'b1;
            end
            else
            begin
                emit            = 1'b1;
                result.byte_out = {nibble_reg, digit[3:0]};
                phase_next      = PH_IDLE;
                nibble_next     = '0;
            end
        end
        else if (!escaped_mode_reg)
        begin
            // High digit position; a leftover escape phase counts as idle.
            if (last || bad_digit)
            begin
                emit = 1'b1;
            end
            else
            begin
                nibble_next = digit[3:0];
                phase_next  = PH_LOW;
            end
        end
        else if (phase_reg == PH_ESC)
        begin
            if (is_bs)
            begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end
            else if (last || bad_digit)
            begin
                emit = 1'b1;
            end
            else
            begin
                nibble_next = digit[3:0];
                phase_next  = PH_LOW;
            end
        end
        else if (is_bs)
        begin
            if (last)
            begin
                emit = 1'b1;
            end
            else
            begin
                phase_next = PH_ESC;
            end
        end
        else
        begin
            emit = 1'b1;
        end

        // Error cases: every path above that emits without settling the phase.
        if (!discard_reg && emit && phase_next == phase_reg
            && !(phase_reg == PH_IDLE && escaped_mode_reg && !is_bs))
        begin
            result       = '{byte_out: 8'h00, format_error: 1'b1, string_done: 1'b1};
            phase_next   = PH_IDLE;
            nibble_next  = '0;
            discard_next = !last;
        end
    end

    // Input register: load on transfer, clear when its item moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_item_reg <= in_data;
        end
    end

    // Decode state and mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            nibble_reg       <= '0;
            discard_reg      <= 1'b0;
            escaped_mode_reg <= 1'b1;
        end
        else
        begin
            if (fire)
            begin
                phase_reg   <= phase_next;
                nibble_reg  <= nibble_next;
                discard_reg <= discard_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                escaped_mode_reg <= cfg_data;
            end
        end
    end

    // Result register: hold while stalled, otherwise take this cycle's result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= fire && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            out_item_reg <= result;
        end
    end

endmodule

`default_nettype wire

// ===== design/ehd_checker.sv =====
// ----------------------------------------------------------------------------
// ehd_checker
// Port-level checks for the escaped hex text decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "escaped_hex_text_decoder_assert.svh"

module ehd_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_ready,
    input ehd_pkg::in_item_t  in_data,
    input wire                out_valid,
    input wire                out_ready,
    input ehd_pkg::out_item_t out_data,
    input wire                cfg_valid,
    input wire                cfg_ready,
    input wire                cfg_data
);
    import ehd_pkg::*;

    logic unused_inputs;
    assign unused_inputs = ^{in_valid, in_data, cfg_valid, cfg_ready, cfg_data};

    // An error result carries a zero byte and closes its string.
    `EHD_ASSERT_IMPLY(a_error_closes, clk, rst_n, out_valid && out_data.format_error, out_data.string_done && out_data.byte_out == 8'h00)

    // With nothing waiting at the output, the input side never stalls.
    `EHD_ASSERT_IMPLY(a_ready_when_drained, clk, rst_n, !out_valid, in_ready)

    // A result that is not taken stays put.
    `EHD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind escaped_hex_text_decoder ehd_checker u_ehd_checker (.*);

`default_nettype wire
